// File: rtl/core/sadq_pkg.sv
package sadq_pkg;

  localparam int unsigned LevelWidth   = 15;
  localparam int unsigned AxisWidth    = 16;
  localparam int unsigned HatWidth     = 4;
  localparam int unsigned InDataWidth  = 40;
  localparam int unsigned OutDataWidth = 8;
  localparam int unsigned AddrWidth    = 4;
  localparam int unsigned RegWidth     = 32;

  localparam int unsigned DebounceSamplesDefault = 2;

  localparam logic [LevelWidth-1:0] CenterBandReset   = 15'd8000;
  localparam logic [LevelWidth-1:0] PressLevelReset   = 15'd24000;
  localparam logic [LevelWidth-1:0] ReleaseLevelReset = 15'd18000;

  // register index taken from paddr[3:2]
  localparam logic [1:0] RegCenterBand   = 2'd0;
  localparam logic [1:0] RegPressLevel   = 2'd1;
  localparam logic [1:0] RegReleaseLevel = 2'd2;

  localparam logic [1:0] KindPoll   = 2'd0;
  localparam logic [1:0] KindAttach = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;

  localparam logic [1:0] DirRest = 2'b00;
  localparam logic [1:0] DirPos  = 2'b01;
  localparam logic [1:0] DirNeg  = 2'b11;

  typedef struct packed {
    logic [LevelWidth-1:0] center_band;
    logic [LevelWidth-1:0] press_level;
    logic [LevelWidth-1:0] release_level;
  } levels_t;

  typedef struct packed {
    logic poll;
    logic attach;
    logic clear;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [1:0]     y_direction;
    logic signed [1:0]     x_direction;
    logic [HatWidth-1:0]   direction_mask;
  } result_t;

endpackage

// File: rtl/core/sadq_lane.sv
module sadq_lane #(
  parameter int unsigned DEBOUNCE_SAMPLES = sadq_pkg::DebounceSamplesDefault
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sadq_pkg::lane_ctl_t                   ctl_i,
  input  sadq_pkg::levels_t                     levels_i,
  input  logic signed [sadq_pkg::AxisWidth-1:0] raw_i,
  output logic signed [1:0]                     dir_o
);

  localparam logic [1:0] DebounceLimit = 2'(DEBOUNCE_SAMPLES);

  logic              cal_q, cal_d;
  logic signed [1:0] held_q, held_d;
  logic signed [1:0] cand_q, cand_d;
  logic [1:0]        run_q, run_d;

  logic signed [16:0] raw_w;
  logic signed [16:0] center_w, press_w, release_w;
  logic               in_band;
  logic signed [1:0]  next_dir;
  logic signed [1:0]  held_t, cand_t;
  logic [1:0]         run_t, run_inc;

  assign raw_w     = {raw_i[15], raw_i};
  assign center_w  = $signed({2'b00, levels_i.center_band});
  assign press_w   = $signed({2'b00, levels_i.press_level});
  assign release_w = $signed({2'b00, levels_i.release_level});

  assign in_band = (raw_w > -center_w) && (raw_w < center_w);
  assign run_inc = (run_q == 2'd3) ? 2'd3 : run_q + 2'd1;

  // hysteresis: press from rest, release from a held direction
  always_comb begin
    next_dir = sadq_pkg::DirRest;
    if (held_q == sadq_pkg::DirNeg) begin
      next_dir = (raw_w < -release_w) ? sadq_pkg::DirNeg : sadq_pkg::DirRest;
    end else if (held_q == sadq_pkg::DirPos) begin
      next_dir = (raw_w > release_w) ? sadq_pkg::DirPos : sadq_pkg::DirRest;
    end else if (raw_w < -press_w) begin
      next_dir = sadq_pkg::DirNeg;
    end else if (raw_w > press_w) begin
      next_dir = sadq_pkg::DirPos;
    end
  end

  // debounce on consecutive equal candidates
  always_comb begin
    held_t = held_q;
    cand_t = next_dir;
    run_t  = 2'd0;
    if (next_dir != held_q) begin
      if (next_dir == cand_q) begin
        run_t = run_inc;
      end else begin
        run_t = 2'd1;
      end
      if (run_t >= DebounceLimit) begin
        held_t = next_dir;
        run_t  = 2'd0;
      end
    end
  end

  always_comb begin
    cal_d  = cal_q;
    held_d = held_q;
    cand_d = cand_q;
    run_d  = run_q;
    if (ctl_i.clear) begin
      cal_d  = 1'b0;
      held_d = sadq_pkg::DirRest;
      cand_d = sadq_pkg::DirRest;
      run_d  = 2'd0;
    end else if (ctl_i.attach) begin
      if (in_band) begin
        cal_d = 1'b1;
      end
    end else if (ctl_i.poll) begin
      if (!cal_q && !in_band) begin
        held_d = sadq_pkg::DirRest;
        cand_d = sadq_pkg::DirRest;
        run_d  = 2'd0;
      end else begin
        cal_d  = 1'b1;
        held_d = held_t;
        cand_d = cand_t;
        run_d  = run_t;
      end
    end
  end

  assign dir_o = ctl_i.poll ? held_d : sadq_pkg::DirRest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q  <= 1'b0;
      held_q <= sadq_pkg::DirRest;
      cand_q <= sadq_pkg::DirRest;
      run_q  <= 2'd0;
    end else begin
      cal_q  <= cal_d;
      held_q <= held_d;
      cand_q <= cand_d;
      run_q  <= run_d;
    end
  end

endmodule

// File: rtl/core/sadq_merge.sv
module sadq_merge (
  input  logic                          hat_en_i,
  input  logic [sadq_pkg::HatWidth-1:0] hat_bits_i,
  input  logic signed [1:0]             x_dir_i,
  input  logic signed [1:0]             y_dir_i,
  output sadq_pkg::result_t             result_o
);

  logic [sadq_pkg::HatWidth-1:0] axis_mask;

  // bit0 up, bit1 down, bit2 left, bit3 right
  assign axis_mask = {x_dir_i == sadq_pkg::DirPos, x_dir_i == sadq_pkg::DirNeg,
                      y_dir_i == sadq_pkg::DirPos, y_dir_i == sadq_pkg::DirNeg};

  assign result_o.direction_mask = axis_mask | (hat_en_i ? hat_bits_i : '0);
  assign result_o.x_direction    = x_dir_i;
  assign result_o.y_direction    = y_dir_i;

endmodule

// File: rtl/core/stick_axis_direction_qualifier.sv
// stick_axis_direction_qualifier
//
// Input stream: one transaction per poll sample, attach or remove event.
// tuser carries the kind, tdata the two stick axes, hat bits and the
// device description used on attach. Output stream: one transaction per
// input transaction with the direction mask and the per-axis directions.
// Two lanes qualify the axes side by side (centering, hysteresis, debounce)
// and a merge stage folds them with the hat into the mask.
// The result is registered into the output buffer when the input is accepted; one
// transaction is taken every cycle while the output buffer is not full.
// A two-entry output buffer keeps input ready high while one result waits,
// so a stalled receiver blocks the input only after two results pile up.
// Reset clears device presence, all lane state and the output buffer, and
// loads the thresholds with their defaults. Thresholds are written over the APB port at
// byte addresses 0, 4 and 8; the user must do so only while the stream is idle, as the block does not enforce it.
module stick_axis_direction_qualifier #(
  parameter int unsigned DEBOUNCE_SAMPLES = sadq_pkg::DebounceSamplesDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // axis_x, axis_y, hat_bits, axes_reported, hat_reported, zero pad
  input  logic [sadq_pkg::InDataWidth-1:0]     s_axis_tdata,
  // kind
  input  logic [1:0]                           s_axis_tuser,
  // master stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // direction_mask, x_direction, y_direction
  output logic [sadq_pkg::OutDataWidth-1:0]    m_axis_tdata,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sadq_pkg::AddrWidth-1:0]       paddr,
  input  logic [sadq_pkg::RegWidth-1:0]        pwdata,
  output logic [sadq_pkg::RegWidth-1:0]        prdata,
  output logic                                 pready
);

  sadq_pkg::levels_t levels_q;
  logic              cfg_wr;
  logic [1:0]        reg_idx;

  logic       present_q;
  logic [1:0] axes_q;
  logic       hat_q;

  logic                           in_acc;
  logic [1:0]                     kind;
  logic signed [15:0]             axis_x, axis_y;
  logic [sadq_pkg::HatWidth-1:0]  hat_bits;
  logic [1:0]                     axes_rep, axes_new;
  logic                           hat_rep;
  logic                           poll_ev, attach_ev, remove_ev;

  sadq_pkg::lane_ctl_t ctl_x, ctl_y;
  logic signed [1:0]   dir_x, dir_y;
  sadq_pkg::result_t   result;

  sadq_pkg::result_t out_q, skid_q;
  logic              out_vld_q, skid_vld_q;
  logic              pop;

  // configuration
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      sadq_pkg::RegCenterBand:   prdata = {17'd0, levels_q.center_band};
      sadq_pkg::RegPressLevel:   prdata = {17'd0, levels_q.press_level};
      sadq_pkg::RegReleaseLevel: prdata = {17'd0, levels_q.release_level};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q.center_band   <= sadq_pkg::CenterBandReset;
      levels_q.press_level   <= sadq_pkg::PressLevelReset;
      levels_q.release_level <= sadq_pkg::ReleaseLevelReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sadq_pkg::RegCenterBand:   levels_q.center_band   <= pwdata[14:0];
        sadq_pkg::RegPressLevel:   levels_q.press_level   <= pwdata[14:0];
        sadq_pkg::RegReleaseLevel: levels_q.release_level <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // input decode
  assign s_axis_tready = !skid_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser;
  assign axis_x        = s_axis_tdata[15:0];
  assign axis_y        = s_axis_tdata[31:16];
  assign hat_bits      = s_axis_tdata[35:32];
  assign axes_rep      = s_axis_tdata[37:36];
  assign hat_rep       = s_axis_tdata[38];
  assign axes_new      = (axes_rep == 2'd3) ? 2'd2 : axes_rep;

  assign poll_ev   = in_acc && (kind == sadq_pkg::KindPoll) && present_q;
  assign attach_ev = in_acc && (kind == sadq_pkg::KindAttach) && !present_q;
  assign remove_ev = in_acc && (kind == sadq_pkg::KindRemove) && present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      axes_q    <= 2'd0;
      hat_q     <= 1'b0;
    end else if (attach_ev) begin
      present_q <= 1'b1;
      axes_q    <= axes_new;
      hat_q     <= hat_rep;
    end else if (remove_ev) begin
      present_q <= 1'b0;
      axes_q    <= 2'd0;
      hat_q     <= 1'b0;
    end
  end

  // lanes
  assign ctl_x.poll   = poll_ev && (axes_q != 2'd0);
  assign ctl_x.attach = attach_ev && (axes_new != 2'd0);
  assign ctl_x.clear  = remove_ev;
  assign ctl_y.poll   = poll_ev && (axes_q == 2'd2);
  assign ctl_y.attach = attach_ev && (axes_new == 2'd2);
  assign ctl_y.clear  = remove_ev;

  sadq_lane #(.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_x),
    .levels_i (levels_q),
    .raw_i    (axis_x),
    .dir_o    (dir_x)
  );

  sadq_lane #(.DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl_y),
    .levels_i (levels_q),
    .raw_i    (axis_y),
    .dir_o    (dir_y)
  );

  sadq_merge u_merge (
    .hat_en_i   (poll_ev && hat_q),
    .hat_bits_i (hat_bits),
    .x_dir_i    (dir_x),
    .y_dir_i    (dir_y),
    .result_o   (result)
  );

  // two-entry output buffer
  assign pop = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        if (out_vld_q && !pop) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (pop) begin
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && skid_vld_q) begin
      out_q <= skid_q;
      if (in_acc) begin
        skid_q <= result;
      end
    end else if (in_acc) begin
      if (out_vld_q && !pop) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while main entry empty");

  a_absent_no_axes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !present_q |-> (axes_q == 2'd0) && !hat_q)
    else $error("axes or hat recorded without a device");

  a_x_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[5:4] != 2'b10))
    else $error("illegal horizontal direction code");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !m_axis_tready) |=> !s_axis_tready)
    else $error("input ready while output buffer full");
`endif

endmodule

// File: dv/tb_top.sv
module tb_top;

  localparam int Debounce = sadq_pkg::DebounceSamplesDefault;
  // kind value the block must ignore
  localparam logic [1:0] KindSpare = 2'd3;
  // register index beyond the last threshold
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int HoldCycles = 300;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  // axis_x, axis_y, hat_bits, axes_reported, hat_reported, zero pad
  logic [sadq_pkg::InDataWidth-1:0]  s_axis_tdata = '0;
  // kind
  logic [1:0]                        s_axis_tuser = sadq_pkg::KindPoll;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // direction_mask, x_direction, y_direction
  logic [sadq_pkg::OutDataWidth-1:0] m_axis_tdata;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [sadq_pkg::AddrWidth-1:0]    paddr = '0;
  logic [sadq_pkg::RegWidth-1:0]     pwdata = '0;
  logic [sadq_pkg::RegWidth-1:0]     prdata;
  logic                              pready;

  stick_axis_direction_qualifier #(
    .DEBOUNCE_SAMPLES(Debounce)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // thresholds as the block should hold them
  int cfg_band    = sadq_pkg::CenterBandReset;
  int cfg_press   = sadq_pkg::PressLevelReset;
  int cfg_release = sadq_pkg::ReleaseLevelReset;

  // stick state mirrored per lane (0 horizontal, 1 vertical)
  bit stick_present;
  int stick_axes;
  bit stick_hat;
  bit lane_cal[2];
  int lane_held[2];
  int lane_cand[2];
  int lane_run[2];

  sadq_pkg::result_t pending_dirs[$];
  int mismatch_count;
  int dir_results_seen;
  int events_sent;
  int settings_applied;
  int src_idle_pct;
  int snk_stall_pct;
  bit hold_req;
  int hold_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 600000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit in_band(int raw);
    return raw > -cfg_band && raw < cfg_band;
  endfunction

  function automatic void clear_lanes();
    for (int i = 0; i < 2; i++) begin
      lane_cal[i]  = 1'b0;
      lane_held[i] = 0;
      lane_cand[i] = 0;
      lane_run[i]  = 0;
    end
  endfunction

  function automatic int qualify_lane(int a, int raw);
    int nxt;
    nxt = 0;
    if (a >= stick_axes) return 0;
    if (!lane_cal[a]) begin
      if (in_band(raw)) begin
        lane_cal[a] = 1'b1;
      end else begin
        lane_held[a] = 0;
        lane_cand[a] = 0;
        lane_run[a]  = 0;
        return 0;
      end
    end
    if (lane_held[a] < 0) nxt = (raw < -cfg_release) ? -1 : 0;
    else if (lane_held[a] > 0) nxt = (raw > cfg_release) ? 1 : 0;
    else if (raw < -cfg_press) nxt = -1;
    else if (raw > cfg_press) nxt = 1;

    if (nxt != lane_held[a]) begin
      if (nxt == lane_cand[a]) begin
        if (lane_run[a] < 3) lane_run[a]++;
      end else begin
        lane_cand[a] = nxt;
        lane_run[a]  = 1;
      end
      if (lane_run[a] >= Debounce) begin
        lane_held[a] = nxt;
        lane_run[a]  = 0;
      end
    end else begin
      lane_cand[a] = nxt;
      lane_run[a]  = 0;
    end
    return lane_held[a];
  endfunction

  function automatic sadq_pkg::result_t predict_directions(logic [1:0] kind, int rx, int ry,
                                                           logic [3:0] hat, logic [1:0] axes,
                                                           logic has_hat);
    sadq_pkg::result_t r;
    int dx;
    int dy;
    logic [3:0] mask;
    dx   = 0;
    dy   = 0;
    mask = '0;
    if (kind == sadq_pkg::KindAttach) begin
      if (!stick_present) begin
        stick_present = 1'b1;
        stick_axes    = (axes > 2) ? 2 : int'(axes);
        stick_hat     = has_hat;
        if (stick_axes > 0 && in_band(rx)) lane_cal[0] = 1'b1;
        if (stick_axes > 1 && in_band(ry)) lane_cal[1] = 1'b1;
      end
    end else if (kind == sadq_pkg::KindRemove) begin
      if (stick_present) begin
        stick_present = 1'b0;
        stick_axes    = 0;
        stick_hat     = 1'b0;
        clear_lanes();
      end
    end else if (kind == sadq_pkg::KindPoll && stick_present) begin
      if (stick_hat) mask |= hat;
      dx = qualify_lane(0, rx);
      dy = qualify_lane(1, ry);
      if (dx < 0) mask |= 4'b0100;
      if (dx > 0) mask |= 4'b1000;
      if (dy < 0) mask |= 4'b0001;
      if (dy > 0) mask |= 4'b0010;
    end
    r.direction_mask = mask;
    r.x_direction    = 2'(dx);
    r.y_direction    = 2'(dy);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic send_event(logic [1:0] kind, logic signed [15:0] ax, logic signed [15:0] ay,
                            logic [3:0] hat, logic [1:0] axes, logic has_hat);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, has_hat, axes, hat, ay, ax};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_dirs.push_back(predict_directions(kind, ax, ay, hat, axes, has_hat));
    events_sent++;
  endtask

  task automatic poll(int ax, int ay, logic [3:0] hat);
    send_event(sadq_pkg::KindPoll, 16'(ax), 16'(ay), hat, 2'd0, 1'b0);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_dirs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_level(logic [1:0] idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {17'($urandom), 15'(value)};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sadq_pkg::RegCenterBand:   cfg_band    = value & 'h7fff;
      sadq_pkg::RegPressLevel:   cfg_press   = value & 'h7fff;
      sadq_pkg::RegReleaseLevel: cfg_release = value & 'h7fff;
      default: ;
    endcase
  endtask

  task automatic apply_setting(int k);
    int band;
    int press;
    int rel;
    case (k)
      0: begin
        band  = sadq_pkg::CenterBandReset;
        press = sadq_pkg::PressLevelReset;
        rel   = sadq_pkg::ReleaseLevelReset;
      end
      1: begin
        band  = $urandom_range(12000, 2000);
        press = $urandom_range(30000, 16000);
        rel   = $urandom_range(press, 8000);
      end
      2: begin band = 32767; press = 0; rel = 0; end
      3: begin band = 0; press = 32767; rel = 32767; end
      default: begin
        band  = $urandom_range(32767);
        press = $urandom_range(32767);
        rel   = $urandom_range(32767);
      end
    endcase
    write_level(sadq_pkg::RegCenterBand, band);
    write_level(sadq_pkg::RegPressLevel, press);
    write_level(sadq_pkg::RegReleaseLevel, rel);
    settings_applied++;
  endtask

  // values clustered around the thresholds, plus extremes and noise
  function automatic int pick_axis();
    int lvl;
    int v;
    case ($urandom_range(6))
      0: lvl = cfg_band;
      1: lvl = cfg_press;
      2: lvl = cfg_release;
      3: return int'($urandom_range(65535)) - 32768;
      4: return int'($urandom_range(2000)) - 1000;
      5: return $urandom_range(1) ? 32767 : -32768;
      default: lvl = $urandom_range(32767);
    endcase
    v = lvl + int'($urandom_range(4)) - 2;
    if ($urandom_range(1)) v = -v;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic run_random(int n);
    int cur_x;
    int cur_y;
    int r;
    cur_x = 0;
    cur_y = 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_event(2'($urandom_range(3)), 16'($urandom), 16'($urandom), 4'($urandom),
                   2'($urandom), 1'($urandom));
      end else if (!stick_present) begin
        // mostly centered so the lanes calibrate on attach
        cur_x = ($urandom_range(3) != 0) ? int'($urandom_range(2000)) - 1000 : pick_axis();
        cur_y = ($urandom_range(3) != 0) ? int'($urandom_range(2000)) - 1000 : pick_axis();
        send_event(sadq_pkg::KindAttach, 16'(cur_x), 16'(cur_y), 4'($urandom), 2'($urandom),
                   1'($urandom));
      end else if (r < 11) begin
        send_event(sadq_pkg::KindRemove, 16'($urandom), 16'($urandom), 4'($urandom),
                   2'($urandom), 1'($urandom));
      end else begin
        // sticky readings let the debounce count up
        if ($urandom_range(99) < 40) cur_x = pick_axis();
        if ($urandom_range(99) < 40) cur_y = pick_axis();
        send_event(sadq_pkg::KindPoll, 16'(cur_x), 16'(cur_y), 4'($urandom), 2'($urandom),
                   1'($urandom));
      end
    end
  endtask

  task automatic test_directed();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    poll(32767, -32768, 4'hf);
    send_event(sadq_pkg::KindRemove, 16'sd0, 16'sd0, 4'h0, 2'd2, 1'b1);
    send_event(KindSpare, 16'sd100, 16'sd100, 4'hf, 2'd2, 1'b1);
    send_event(sadq_pkg::KindAttach, 16'sd0, -16'sd7999, 4'h0, 2'd3, 1'b1);
    send_event(sadq_pkg::KindAttach, 16'sh7fff, 16'sh7fff, 4'h0, 2'd0, 1'b0);
    poll(32767, 0, 4'h0);
    poll(32767, 0, 4'h0);
    poll(20000, -32768, 4'h1);
    poll(18000, -32768, 4'h0);
    poll(18000, -24000, 4'h2);
    poll(-24001, 0, 4'hf);
    poll(0, 0, 4'h0);
    poll(-32768, 0, 4'h8);
    poll(-32768, 0, 4'h0);
    send_event(sadq_pkg::KindRemove, 16'sd0, 16'sd0, 4'h0, 2'd0, 1'b0);
    // lane left uncalibrated: the band edge itself is outside
    send_event(sadq_pkg::KindAttach, 16'sd8000, 16'sd0, 4'h0, 2'd1, 1'b0);
    poll(-8000, 0, 4'hf);
    poll(100, 32767, 4'hf);
    poll(30000, 32767, 4'h0);
    poll(30000, 32767, 4'h0);
    send_event(sadq_pkg::KindRemove, 16'sd0, 16'sd0, 4'h0, 2'd0, 1'b0);
    send_event(sadq_pkg::KindAttach, 16'sd0, 16'sd0, 4'h0, 2'd0, 1'b1);
    poll(32767, 32767, 4'h5);
    send_event(sadq_pkg::KindRemove, 16'sd0, 16'sd0, 4'h0, 2'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    if (!stick_present) send_event(sadq_pkg::KindAttach, 16'sd0, 16'sd0, 4'h0, 2'd2, 1'b1);
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) poll(pick_axis(), pick_axis(), 4'($urandom));
    // sender stays quiet until everything has come out
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int src_mix[4];
    int snk_mix[4];
    src_mix = '{0, 65, 0, 23};
    snk_mix = '{0, 0, 65, 23};
    write_level(RegUnused, $urandom);
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = src_mix[p];
      snk_stall_pct = snk_mix[p];
      for (int k = 0; k < 5; k++) begin
        wait_drained();
        apply_setting(k);
        run_random(100);
      end
    end
    wait_drained();
  endtask

  // receiver side, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : dir_check
    sadq_pkg::result_t got;
    sadq_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      dir_results_seen++;
      if (pending_dirs.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata, 0);
      end else begin
        want = pending_dirs.pop_front();
        if (got.direction_mask !== want.direction_mask)
          report_mismatch("direction_mask", got.direction_mask, want.direction_mask);
        if (got.x_direction !== want.x_direction)
          report_mismatch("x_direction", got.x_direction, want.x_direction);
        if (got.y_direction !== want.y_direction)
          report_mismatch("y_direction", got.y_direction, want.y_direction);
      end
    end
  end

  initial begin
    clear_lanes();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_traffic();
    repeat (10) @(posedge clk_i);
    $display("covered %0d stream events, %0d results checked, %0d threshold settings",
             events_sent, dir_results_seen, settings_applied);
    $display("idle mixes on both sides plus one long receiver hold-off; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
